// File: hw/rtl/trrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrt_pkg
// Shared types and codes of the tcp receive reassembly tracker.
// ----------------------------------------------------------------------------
package trrt_pkg;

	// ring size in bytes, a power of two so ring arithmetic is a mask
	localparam int RING_BYTES = 65536;

	// event kinds
	localparam logic [1:0] FN_SYN  = 2'd0;
	localparam logic [1:0] FN_SEG  = 2'd1;
	localparam logic [1:0] FN_FIN  = 2'd2;
	localparam logic [1:0] FN_READ = 2'd3;

	// connection phases
	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_EST  = 2'd1;
	localparam logic [1:0] PH_FIN  = 2'd2;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_STATE = 3'd1,
		ST_SPACE = 3'd2,
		ST_ORDER = 3'd3,
		ST_READY = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_EVENT,
		OP_SPACE,
		OP_SCAN,
		OP_TRIM,
		OP_INSERT,
		OP_ADVANCE,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic seg_go;
		logic space_ok;
		logic scan_hit;
		logic adv_stop;
	} flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/trrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrt_ctrl
// Sequencer: walks one event through check, space, scan, trim, insert, advance and result.
// ----------------------------------------------------------------------------
module trrt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire trrt_pkg::flags_t flags,
	output trrt_pkg::cmd_t       cmd
);
	import trrt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_EVENT, S_SPACE, S_SCAN, S_TRIM, S_INSERT, S_ADV, S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// command decode
	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_EVENT:  cmd.op = OP_EVENT;
			S_SPACE:  cmd.op = OP_SPACE;
			S_SCAN:   cmd.op = OP_SCAN;
			S_TRIM:   cmd.op = OP_TRIM;
			S_INSERT: cmd.op = OP_INSERT;
			S_ADV:    cmd.op = OP_ADVANCE;
			S_RESULT: cmd.op = out_free ? OP_RESULT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_RESULT && out_free) || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_EVENT;
				S_EVENT:  state_q <= flags.seg_go ? S_SPACE : S_RESULT;
				S_SPACE:  state_q <= flags.space_ok ? S_SCAN : S_RESULT;
				S_SCAN:   if (flags.scan_hit) state_q <= S_TRIM;
				S_TRIM:   state_q <= S_INSERT;
				S_INSERT: state_q <= S_ADV;
				S_ADV:    if (flags.adv_stop) state_q <= S_RESULT;
				S_RESULT: if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/trrt_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrt_dpath
// Connection state, sorted pending table, ring heads and result registers.
// ----------------------------------------------------------------------------
module trrt_dpath #(
	parameter int MAX_PENDING = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire trrt_pkg::cmd_t   cmd,
	output trrt_pkg::flags_t      flags,
	input  wire logic [1:0]       func,
	input  wire logic [63:0]      seq_number,
	input  wire logic [15:0]      byte_count,
	output logic [2:0]            status,
	output logic [15:0]           accepted_count,
	output logic [15:0]           ring_position,
	output logic [63:0]           next_expected,
	output logic [15:0]           ready_count,
	output logic [15:0]           free_count
);
	import trrt_pkg::*;

	localparam int IW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int PW = $clog2(MAX_PENDING + 1);
	// ring size is a power of two, so ring arithmetic is a mask
	localparam logic [15:0] RMASK = 16'(RING_BYTES - 1);

	// current event
	logic [1:0]  func_q;
	logic [63:0] seq_q;
	logic [15:0] len_q;
	status_t     status_q;
	logic [15:0] acc_q;
	logic [15:0] pos_q;

	// connection state
	logic [1:0]  phase_q;
	logic [63:0] next_q;
	logic [15:0] wh_q;
	logic [15:0] rh_q;
	logic [PW-1:0] used_q;
	logic [IW-1:0] idx_q;
	logic [15:0] end_q;
	logic [63:0] start_q [MAX_PENDING];
	logic [15:0] plen_q  [MAX_PENDING];

	logic [63:0] old_d;
	logic        dup_d;
	logic [15:0] ready_d;
	logic [15:0] far_d;
	logic [15:0] free_d;
	logic [63:0] gap_d;
	logic        idx_end_d;

	// combinational helpers
	always_comb begin
		old_d     = next_q - seq_q;
		dup_d     = (seq_q < next_q) && (old_d >= {48'd0, len_q});
		ready_d   = (wh_q - rh_q) & RMASK;
		far_d     = (used_q != '0) ? ((wh_q + end_q - next_q[15:0]) & RMASK) : wh_q;
		free_d    = RMASK - ((far_d - rh_q) & RMASK);
		gap_d     = start_q[idx_q] - seq_q;
		idx_end_d = (PW'(idx_q) == used_q);
	end

	// status to the sequencer
	always_comb begin
		flags.seg_go   = (func_q == FN_SEG) && (phase_q == PH_EST) && !dup_d;
		flags.space_ok = (len_q <= free_d) && (used_q < PW'(MAX_PENDING));
		flags.scan_hit = idx_end_d || (seq_q < start_q[idx_q]);
		flags.adv_stop = (used_q == '0) || (next_q != start_q[0]);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			next_q  <= '0;
			wh_q    <= '0;
			rh_q    <= '0;
			used_q  <= '0;
		end else begin
			case (cmd.op)
				OP_EVENT: begin
					case (func_q)
						FN_SYN: begin
							if (phase_q == PH_WAIT) begin
								next_q  <= seq_q + 64'd1;
								phase_q <= PH_EST;
							end
						end
						FN_FIN: if (phase_q == PH_EST) phase_q <= PH_FIN;
						FN_READ: begin
							if (len_q != '0 && ready_d >= len_q)
								rh_q <= (rh_q + len_q) & RMASK;
						end
						default: ;
					endcase
				end
				OP_INSERT: used_q <= used_q + PW'(1);
				OP_ADVANCE: begin
					if (!flags.adv_stop) begin
						next_q <= next_q + {48'd0, plen_q[0]};
						wh_q   <= (wh_q + plen_q[0]) & RMASK;
						used_q <= used_q - PW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// event payload, table and results
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q   <= func;
				seq_q    <= seq_number;
				len_q    <= byte_count;
				status_q <= ST_OK;
				acc_q    <= '0;
				pos_q    <= '0;
			end
			OP_EVENT: begin
				case (func_q)
					FN_SYN: if (phase_q != PH_WAIT) status_q <= ST_STATE;
					FN_SEG: begin
						if (phase_q != PH_EST) begin
							status_q <= ST_STATE;
						end else if (seq_q < next_q && !dup_d) begin
							seq_q <= next_q;
							len_q <= len_q - old_d[15:0];
						end
					end
					FN_FIN: if (phase_q != PH_EST) status_q <= ST_STATE;
					default: begin
						pos_q <= rh_q;
						if (len_q != '0) begin
							if (ready_d < len_q)
								status_q <= ST_READY;
							else
								acc_q <= len_q;
						end
					end
				endcase
			end
			OP_SPACE: begin
				idx_q <= '0;
				if (len_q > free_d)
					status_q <= ST_SPACE;
				else if (used_q >= PW'(MAX_PENDING))
					status_q <= ST_FULL;
				else
					pos_q <= (wh_q + seq_q[15:0] - next_q[15:0]) & RMASK;
			end
			OP_SCAN: if (!flags.scan_hit) idx_q <= idx_q + IW'(1);
			OP_TRIM: begin
				if (!idx_end_d && {48'd0, len_q} >= gap_d)
					len_q <= gap_d[15:0];
			end
			OP_INSERT: begin
				// open a slot at the scan position and shift later entries up
				for (int i = 1; i < MAX_PENDING; i++) begin
					if (IW'(i) > idx_q && PW'(i) <= used_q) begin
						start_q[i] <= start_q[i-1];
						plen_q[i]  <= plen_q[i-1];
					end
				end
				start_q[idx_q] <= seq_q;
				plen_q[idx_q]  <= len_q;
				acc_q          <= len_q;
				if (idx_end_d)
					end_q <= seq_q[15:0] + len_q;
			end
			OP_ADVANCE: begin
				if (!flags.adv_stop) begin
					for (int i = 0; i < MAX_PENDING - 1; i++) begin
						start_q[i] <= start_q[i+1];
						plen_q[i]  <= plen_q[i+1];
					end
				end else if (used_q != '0 && next_q >= start_q[0]) begin
					status_q <= ST_ORDER;
					acc_q    <= '0;
				end
			end
			OP_RESULT: begin
				status         <= status_q;
				accepted_count <= acc_q;
				ring_position  <= pos_q;
				next_expected  <= next_q;
				ready_count    <= ready_d;
				free_count     <= free_d;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/tcp_receive_reassembly_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_tracker_top
// Receive-side reassembly tracker: ring positions and ordering for one flow.
// ----------------------------------------------------------------------------
// One event beat gives one result beat. Syn, fin, read, wrong-state and
// duplicate segments go from the event step straight to the result; segments
// refused for space or a full table pass the space check first; an accepted
// segment then runs the insertion scan over the pending entries it steps
// over, a trim and an insert, and the advance over the contiguous entries
// consumed, both by the one-entry-per-cycle walk of the pending table. A new
// event is taken the cycle after the previous result has reached the output
// register; while the result stalls, the sequencer holds in its result step.
// The ring is 65536 bytes.
module tcp_receive_reassembly_tracker_top #(
	parameter int MAX_PENDING = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] seq_number,
	input  wire logic [15:0] byte_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      accepted_count,
	output logic [15:0]      ring_position,
	output logic [63:0]      next_expected,
	output logic [15:0]      ready_count,
	output logic [15:0]      free_count
);
	import trrt_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	// sequencer
	trrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	// state and table
	trrt_dpath #(
		.MAX_PENDING (MAX_PENDING)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.flags          (flags),
		.func           (func),
		.seq_number     (seq_number),
		.byte_count     (byte_count),
		.status         (status),
		.accepted_count (accepted_count),
		.ring_position  (ring_position),
		.next_expected  (next_expected),
		.ready_count    (ready_count),
		.free_count     (free_count)
	);

`ifndef SYNTHESIS
	// busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted beat did not make the tracker busy");

	// status codes stay in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL)
		else $error("result status out of range");

	// errors never report accepted bytes
	a_err_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> accepted_count == 16'd0)
		else $error("error result with nonzero accepted count");

	// no result is produced while a beat is still being taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after accept");
`endif

endmodule
`default_nettype wire
